>>> rtl/core/bdq_pkg.sv
package bdq_pkg;

  localparam int Depth = 16;
  localparam int IdxW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam int OutCntW = 5;
  localparam int DataW = 32;
  localparam int LimW = 31;
  localparam logic [LimW-1:0] LimitReset = LimW'(99);

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT = 3'd2;
  localparam logic [2:0] CMD_POP_BACK = 3'd3;
  localparam logic [2:0] CMD_SEARCH = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NOMATCH = 2'd3;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic       load;    // capture the input word and run the compares
    logic       commit;  // apply the decided update
  } bdq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] status;
  } bdq_stat_t;

endpackage

>>> rtl/core/bdq_ctrl.sv
module bdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_rdy,
  output logic              out_valid,
  input  logic              out_rdy,
  output bdq_pkg::bdq_cmd_t cmd
);
  import bdq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0] state_r, state_nxt;

  // Take a new word when idle, or when the held result leaves this cycle.
  assign in_rdy    = (state_r == S_IDLE) || (state_r == S_HOLD && out_rdy);
  assign out_valid = (state_r == S_HOLD);
  assign cmd.load   = in_valid && in_rdy;
  assign cmd.commit = (state_r == S_EVAL);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EVAL;
      S_EVAL: state_nxt = S_HOLD;
      S_HOLD: begin
        if (out_rdy) state_nxt = in_valid ? S_EVAL : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  a_hold_until_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rdy |=> out_valid) else $error("result dropped");
  a_eval_then_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid) else $error("evaluate not followed by result");
  a_no_load_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !cmd.load) else $error("load during evaluate");

endmodule

>>> rtl/core/bdq_dp.sv
module bdq_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bdq_pkg::bdq_cmd_t           cmd,
  input  logic [2:0]                  in_cmd,
  input  logic signed [31:0]          in_item,
  input  logic signed [31:0]          in_key,
  input  logic                        cfg_we,
  input  logic [bdq_pkg::LimW-1:0]    cfg_data,
  output bdq_pkg::bdq_stat_t          stat,
  output logic [4:0]                  res_count,
  output logic signed [31:0]          res_front,
  output logic signed [31:0]          res_back
);
  import bdq_pkg::*;

  logic signed [DataW-1:0] cells_r [Depth];
  logic [CntW-1:0] occ_r;
  logic [LimW-1:0] limit_r;
  logic [2:0] op_r;
  logic signed [DataW-1:0] item_r;
  logic [Depth-1:0] eq_r, near_r;
  logic [DataW:0] diff_r [Depth];
  logic [DataW:0] diff_w [Depth];
  logic [1:0] status_r;

  // Exact differences, one bit wider than the data so that none overflows.
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      diff_w[i] = {cells_r[i][DataW-1], cells_r[i]} - {in_key[DataW-1], in_key};
    end
  end

  // Stage one: per-cell equality and nearness, registered.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_cmd;
      item_r <= in_item;
      for (int i = 0; i < Depth; i++) begin
        eq_r[i]   <= (cells_r[i] == in_key) && (CntW'(i) < occ_r);
        near_r[i] <= (CntW'(i) < occ_r) && !diff_w[i][DataW] && (diff_w[i] != '0)
                     && (diff_w[i] < {2'b00, limit_r});
        diff_r[i] <= diff_w[i];
      end
    end
  end

  // Stage two: pick the position; first equal wins, else the smallest near
  // difference. The near lanes are reduced pairwise in a tree, the lower
  // lane being kept on a tie so that the first such entry wins.
  logic [IdxW-1:0] pos;
  logic found;
  logic [Depth-1:0] tree_v;
  logic [DataW:0] tree_d [Depth];
  logic [IdxW-1:0] tree_i [Depth];
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      tree_v[i] = near_r[i];
      tree_d[i] = diff_r[i];
      tree_i[i] = IdxW'(i);
    end
    for (int w = Depth / 2; w >= 1; w = w / 2) begin
      for (int i = 0; i < w; i++) begin
        if (tree_v[2*i+1] && (!tree_v[2*i] || tree_d[2*i+1] < tree_d[2*i])) begin
          tree_v[i] = 1'b1;
          tree_d[i] = tree_d[2*i+1];
          tree_i[i] = tree_i[2*i+1];
        end else begin
          tree_v[i] = tree_v[2*i];
          tree_d[i] = tree_d[2*i];
          tree_i[i] = tree_i[2*i];
        end
      end
    end
    pos = tree_i[0];
    found = tree_v[0];
    if (|eq_r) begin
      found = 1'b1;
      pos = '0;
      for (int i = Depth - 1; i >= 0; i--) if (eq_r[i]) pos = IdxW'(i);
    end
  end

  logic full, empty;
  assign full  = (occ_r >= CntW'(Depth));
  assign empty = (occ_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r    <= '0;
      limit_r  <= LimitReset;
      status_r <= ST_OK;
    end else begin
      if (cfg_we) limit_r <= cfg_data;
      if (cmd.commit) begin
        status_r <= ST_OK;
        case (op_r)
          CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (full) status_r <= ST_FULL;
            else occ_r <= occ_r + 1'b1;
          end
          CMD_POP_FRONT, CMD_POP_BACK: begin
            if (empty) status_r <= ST_EMPTY;
            else occ_r <= occ_r - 1'b1;
          end
          CMD_SEARCH: begin
            if (empty) status_r <= ST_EMPTY;
            else if (full) status_r <= ST_FULL;
            else if (!found) status_r <= ST_NOMATCH;
            else occ_r <= occ_r + 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Cell shifting: a shift register with per-lane selection.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < Depth; i++) begin
        case (op_r)
          CMD_PUSH_FRONT: if (!full) cells_r[i] <= (i == 0) ? item_r : cells_r[(i+Depth-1)%Depth];
          CMD_PUSH_BACK: if (!full && CntW'(i) == occ_r) cells_r[i] <= item_r;
          CMD_POP_FRONT: if (!empty && i < Depth - 1) cells_r[i] <= cells_r[(i+1)%Depth];
          CMD_SEARCH: begin
            if (!empty && !full && found) begin
              if (IdxW'(i) == pos) cells_r[i] <= item_r;
              else if (IdxW'(i) > pos) cells_r[i] <= cells_r[(i+Depth-1)%Depth];
            end
          end
          default: ;
        endcase
      end
    end
  end

  logic [IdxW-1:0] last;
  assign last = IdxW'(occ_r - 1'b1);
  assign stat.status = status_r;
  assign res_count = OutCntW'(occ_r);
  assign res_front = empty ? '0 : cells_r[0];
  assign res_back  = empty ? '0 : cells_r[last];

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CntW'(Depth)) else $error("occupancy overflow");
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && full && (op_r == CMD_PUSH_BACK) |=> $stable(occ_r))
    else $error("push when full changed count");
  a_empty_holds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && empty && (op_r == CMD_POP_BACK) |=> occ_r == '0)
    else $error("pop when empty changed count");

endmodule

>>> rtl/core/bounded_deque_with_near_insert_core.sv
// Bounded deque with near insert.
// Holds up to sixteen signed 32-bit values in order and serves one command
// word at a time on the in_ channel: push front, push back, pop front,
// pop back, or search insert (place before the first entry equal to the
// key, else before the entry lying just above the key by less than the
// nearness limit). Each command word yields exactly one result word on the
// out_ channel carrying status, the count and the front and back values.
// An accepted command is registered through the per-cell compare stage and
// evaluated in the next cycle through the pairwise minimum tree over sixteen
// lanes; its result is presented in the cycle after that. No new command is
// taken while one is being evaluated.
// The result is held in a register while out_tready is low; a new command
// is taken in the cycle that result leaves. The user must write the
// nearness limit via cfg_we/cfg_wdata while idle; the block does not check.
// Reset (rst_n low, synchronous) empties the list, restores the limit to
// 99 and drops any pending result.
module bounded_deque_with_near_insert_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] cmd, [34:3] item_value, [66:35] search_key, [71:67] zero
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] status, [6:2] entry_count, [38:7] front_value,
  // [70:39] back_value, [71] zero
  output logic [71:0] out_tdata,
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata
);
  import bdq_pkg::*;

  bdq_cmd_t  cmd;
  bdq_stat_t stat;
  logic [4:0] res_count;
  logic signed [31:0] res_front, res_back;

  bdq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_rdy(in_tready),
    .out_valid(out_tvalid), .out_rdy(out_tready),
    .cmd(cmd)
  );

  bdq_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_cmd(in_tdata[2:0]),
    .in_item(in_tdata[34:3]),
    .in_key(in_tdata[66:35]),
    .cfg_we(cfg_we), .cfg_data(cfg_wdata),
    .stat(stat), .res_count(res_count),
    .res_front(res_front), .res_back(res_back)
  );

  assign out_tdata = {1'b0, res_back, res_front, res_count, stat.status};

endmodule
